// ===== design/ism_pkg.sv =====
// shared types and constants of the interval set block
// no dependencies; taken in by the result interface, the controller, the datapath and the top level

package ism_pkg;

    // hit counter width and its saturation value
    localparam int HIT_W = 32;
    typedef logic [HIT_W-1:0] t_hits;
    localparam t_hits HIT_MAX = '1;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status STS_OK       = 2'd0;
    localparam t_status STS_FULL     = 2'd1;
    localparam t_status STS_REVERSED = 2'd2;

    // item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN,
        ST_FIN2,
        ST_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic in_ready;
        logic capture;
        logic clr_wr;
        logic cnt_inc;
        logic cnt_rst;
        logic scan_rd;
        logic fin;
        logic fin2;
        logic load_out;
    } t_ctrl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_valid;
        logic cnt_last;
        logic reject;
        logic pipe_busy;
        logic out_full;
        logic out_ready;
    } t_ctrl_sts;

endpackage

// ===== design/ism_in_if.sv =====
// input channel of the interval set block: one load range or one query id per beat
// no dependencies

interface ism_in_if #(
    parameter int ID_BITS = 50
) ();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [ID_BITS-1:0] range_low;
    logic [ID_BITS-1:0] range_high;
    logic [ID_BITS-1:0] query_id;

    modport source (output valid, mode, range_low, range_high, query_id, input ready);
    modport sink   (input valid, mode, range_low, range_high, query_id, output ready);
endinterface

// ===== design/ism_out_if.sv =====
// result channel of the interval set block: one result per beat
// depends on ism_pkg for the status and hit count types

interface ism_out_if #(
    parameter int ID_BITS = 50
) ();
    logic               valid;
    logic               ready;
    ism_pkg::t_status   status;
    logic               hit;
    ism_pkg::t_hits     hits_so_far;
    logic [ID_BITS:0]   covered_total;

    modport source (output valid, status, hit, hits_so_far, covered_total, input ready);
    modport sink   (input valid, status, hit, hits_so_far, covered_total, output ready);
endinterface

// ===== design/ism_ctrl.sv =====
// controller of the interval set block: sequences clearing, scan, drain and write-back
// depends on ism_pkg for the state enum and the command and status structs

module ism_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ism_pkg::t_ctrl_sts i_sts,
    output ism_pkg::t_ctrl_cmd o_cmd
);
    import ism_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.cnt_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_sts.in_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.reject) begin
                    n_state = ST_DONE;
                end else if (i_sts.cnt_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = ST_FIN;
            end
            ST_FIN: begin
                n_state = ST_FIN2;
            end
            ST_FIN2: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_sts.out_full || i_sts.out_ready) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.cnt_last) begin
                    o_cmd.cnt_rst = 1'b1;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.capture  = i_sts.in_valid;
            end
            ST_SCAN: begin
                if (!i_sts.reject) begin
                    o_cmd.scan_rd = 1'b1;
                    if (i_sts.cnt_last) begin
                        o_cmd.cnt_rst = 1'b1;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                o_cmd = '0;
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
            end
            ST_FIN2: begin
                o_cmd.fin2 = 1'b1;
            end
            ST_DONE: begin
                o_cmd.load_out = !i_sts.out_full || i_sts.out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // an accepted beat always starts a scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sts.in_valid && o_cmd.in_ready) |=> (r_state == ST_SCAN))
        else $error("accepted beat did not start a scan");

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!i_sts.out_full || i_sts.out_ready))
        else $error("result register overwritten");

    // write-back only once the scan pipeline has emptied
    a_fin_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> !i_sts.pipe_busy)
        else $error("write-back with scan still in flight");

endmodule

// ===== design/ism_datapath.sv =====
// datapath of the interval set block: interval memory, scan pipeline, accumulators
// and the result register; depends on ism_pkg for types, codes and structs

module ism_datapath #(
    parameter int MAX_INTERVALS = 256,
    parameter int ID_BITS       = 50
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ism_pkg::t_ctrl_cmd i_cmd,
    output ism_pkg::t_ctrl_sts o_sts,
    input  logic               i_in_valid,
    input  logic               i_mode,
    input  logic [ID_BITS-1:0] i_range_low,
    input  logic [ID_BITS-1:0] i_range_high,
    input  logic [ID_BITS-1:0] i_query_id,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output ism_pkg::t_status   o_status,
    output logic               o_hit,
    output ism_pkg::t_hits     o_hits_so_far,
    output logic [ID_BITS:0]   o_covered_total
);
    import ism_pkg::*;

    localparam int IDX_W  = $clog2(MAX_INTERVALS);
    localparam int WORD_W = 2 * ID_BITS + 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_INTERVALS - 1);
    localparam logic [ID_BITS:0] COVER_MAX = {1'b1, {ID_BITS{1'b0}}};

    // memory word: valid, start, end
    logic [WORD_W-1:0]  r_mem [MAX_INTERVALS];
    logic [WORD_W-1:0]  r_rd_word;

    logic [IDX_W-1:0]   r_cnt;

    // captured item
    logic               r_mode;
    logic               r_reversed;
    logic [ID_BITS-1:0] r_key_lo;
    logic [ID_BITS-1:0] r_key_hi;

    // scan pipeline
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_s2_vld;
    logic               r_s2_match;
    logic               r_s2_free;
    logic [IDX_W-1:0]   r_s2_idx;
    logic [ID_BITS-1:0] r_s2_start;
    logic [ID_BITS-1:0] r_s2_end;
    logic [ID_BITS:0]   r_s2_len;

    // accumulators
    logic               r_any;
    logic               r_slot_found;
    logic [IDX_W-1:0]   r_slot;
    logic [ID_BITS-1:0] r_new_lo;
    logic [ID_BITS-1:0] r_new_hi;
    logic [ID_BITS:0]   r_absorbed;
    logic [ID_BITS:0]   r_newlen;

    // persistent state
    logic [ID_BITS:0]   r_union;
    t_hits              r_hits;

    // result register
    logic               r_out_valid;
    t_status            r_out_status;
    logic               r_out_hit;
    t_hits              r_out_hits;
    logic [ID_BITS:0]   r_out_covered;

    logic               w_rd_valid;
    logic [ID_BITS-1:0] w_rd_start;
    logic [ID_BITS-1:0] w_rd_end;
    logic               w_is_load;
    logic               w_inval;
    logic               w_load_ok;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [WORD_W-1:0]  w_wdata;
    t_status            w_status;

    assign w_rd_valid = r_rd_word[WORD_W-1];
    assign w_rd_start = r_rd_word[2*ID_BITS-1:ID_BITS];
    assign w_rd_end   = r_rd_word[ID_BITS-1:0];
    assign w_is_load  = (r_mode == MODE_LOAD);
    assign w_inval    = r_s2_vld && r_s2_match && w_is_load;
    assign w_load_ok  = w_is_load && r_slot_found;

    // status to the controller
    always_comb begin
        o_sts.in_valid  = i_in_valid;
        o_sts.cnt_last  = (r_cnt == LAST_IDX);
        o_sts.reject    = w_is_load && r_reversed;
        o_sts.pipe_busy = r_rd_vld || r_s2_vld;
        o_sts.out_full  = r_out_valid;
        o_sts.out_ready = i_out_ready;
    end

    // entry counter for the clearing pass and the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_rst) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + IDX_W'(1);
        end
    end

    // write port select: clearing, invalidation of absorbed entries, merged entry
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = '0;
        if (i_cmd.clr_wr) begin
            w_we    = 1'b1;
            w_waddr = r_cnt;
        end else if (w_inval) begin
            w_we    = 1'b1;
            w_waddr = r_s2_idx;
        end else if (i_cmd.fin && w_load_ok) begin
            w_we    = 1'b1;
            w_waddr = r_slot;
            w_wdata = {1'b1, r_new_lo, r_new_hi};
        end
    end

    // interval memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd_word <= r_mem[r_cnt];
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode     <= i_mode;
            r_reversed <= (i_range_low > i_range_high);
            if (i_mode == MODE_LOAD) begin
                r_key_lo <= i_range_low;
                r_key_hi <= i_range_high;
            end else begin
                r_key_lo <= i_query_id;
                r_key_hi <= i_query_id;
            end
        end
    end

    // read stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            r_s2_vld <= r_rd_vld;
        end
    end

    // compare stage: overlap with the key range, entry length
    always_ff @(posedge i_clk) begin
        r_rd_idx   <= r_cnt;
        r_s2_idx   <= r_rd_idx;
        r_s2_free  <= !w_rd_valid;
        r_s2_match <= w_rd_valid && (r_key_lo <= w_rd_end) && (w_rd_start <= r_key_hi);
        r_s2_start <= w_rd_start;
        r_s2_end   <= w_rd_end;
        r_s2_len   <= {1'b0, w_rd_end} - {1'b0, w_rd_start} + (ID_BITS+1)'(1);
    end

    // accumulate merged bounds, absorbed size and target slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any        <= 1'b0;
            r_slot_found <= 1'b0;
        end else if (i_cmd.capture) begin
            r_any        <= 1'b0;
            r_slot_found <= 1'b0;
        end else if (r_s2_vld) begin
            if (r_s2_match) r_any <= 1'b1;
            if ((r_s2_match || r_s2_free) && !r_slot_found) r_slot_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_new_lo   <= i_range_low;
            r_new_hi   <= i_range_high;
            r_absorbed <= '0;
        end else if (r_s2_vld) begin
            if (r_s2_match) begin
                if (r_s2_start < r_new_lo) r_new_lo <= r_s2_start;
                if (r_s2_end > r_new_hi)   r_new_hi <= r_s2_end;
                r_absorbed <= r_absorbed + r_s2_len;
            end
            if ((r_s2_match || r_s2_free) && !r_slot_found) r_slot <= r_s2_idx;
        end
    end

    // write-back: union size and hit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_union <= '0;
            r_hits  <= '0;
        end else if (i_cmd.fin) begin
            if (w_load_ok) r_union <= r_union - r_absorbed;
            if (!w_is_load && r_any && (r_hits != HIT_MAX)) r_hits <= r_hits + t_hits'(1);
        end else if (i_cmd.fin2 && w_load_ok) begin
            r_union <= r_union + r_newlen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) r_newlen <= {1'b0, r_new_hi} - {1'b0, r_new_lo} + (ID_BITS+1)'(1);
    end

    // result status
    always_comb begin
        if (w_is_load && r_reversed) begin
            w_status = STS_REVERSED;
        end else if (w_is_load && !r_slot_found) begin
            w_status = STS_FULL;
        end else begin
            w_status = STS_OK;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status  <= w_status;
            r_out_hit     <= !w_is_load && r_any;
            r_out_hits    <= r_hits;
            r_out_covered <= r_union;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_hit           = r_out_hit;
    assign o_hits_so_far   = r_out_hits;
    assign o_covered_total = r_out_covered;

    // hit count never goes down
    a_hits_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_hits >= $past(r_hits)))
        else $error("hit count decreased");

    // union of disjoint intervals never exceeds the id space
    a_union_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_union <= COVER_MAX)
        else $error("union size out of range");

    // invalidation never collides with clearing or the merged write
    a_write_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_inval |-> !(i_cmd.clr_wr || i_cmd.fin))
        else $error("write port conflict");

endmodule

// ===== design/interval_set_merge_and_membership.sv =====
// a load or query is answered after a scan of every table entry, one entry per cycle, a drain
// of the scan pipeline and write-back; a reversed range is rejected without a scan; the next
// beat is taken only once the result is loaded, which waits while an earlier result is unread
// reset: synchronous; afterwards a clearing pass over all MAX_INTERVALS entries empties the table
// and no input beat is taken until it ends
// depends on ism_pkg, ism_in_if, ism_out_if, ism_ctrl and ism_datapath

module interval_set_merge_and_membership #(
    parameter int MAX_INTERVALS = 256,
    parameter int ID_BITS       = 50
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ism_in_if.sink        i_in,
    ism_out_if.source     o_out
);
    import ism_pkg::*;

    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;

    assign i_in.ready = w_cmd.in_ready;

    // sequencer
    ism_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // storage, scan pipeline and result register
    ism_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .ID_BITS       (ID_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_in_valid      (i_in.valid),
        .i_mode          (i_in.mode),
        .i_range_low     (i_in.range_low),
        .i_range_high    (i_in.range_high),
        .i_query_id      (i_in.query_id),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_status        (o_out.status),
        .o_hit           (o_out.hit),
        .o_hits_so_far   (o_out.hits_so_far),
        .o_covered_total (o_out.covered_total)
    );

endmodule
